### design/fkcd_pkg.sv
// Shared types and constants for the framed keyword command decoder.
// Used by fkcd_match, fkcd_frame and framed_keyword_command_decoder; no dependencies.
`default_nettype none

package fkcd_pkg;

  // Size of the command buffer; the write position wraps at this value (8 to 256).
  localparam int unsigned CMD_BUF_SIZE = 32;
  localparam int unsigned WPOS_W       = $clog2(CMD_BUF_SIZE);
  localparam int unsigned WPOS_EXT_W   = WPOS_W + 1;

  // Only the leading bytes of the buffer can ever decide a match: the longest
  // keyword plus its terminating zero.
  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned KIDX_W    = $clog2(KEY_BYTES);
  localparam int unsigned KW_COUNT  = 6;

  localparam logic [7:0] START_CHAR_RESET = 8'd37;
  localparam logic [7:0] END_CHAR_RESET   = 8'd36;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

  // Configuration register indexes.
  localparam logic REG_START_CHAR = 1'b0;
  localparam logic REG_END_CHAR   = 1'b1;

  // Command codes.
  localparam logic [2:0] CODE_WAKED    = 3'd0;
  localparam logic [2:0] CODE_NO_MATCH = 3'd6;

  typedef logic [7:0] byte_t;
  typedef byte_t key_buf_t [KEY_BYTES];

  // Keywords, zero padded, in priority order.
  localparam byte_t KW_TEXT [KW_COUNT][KEY_BYTES] = '{
    '{"w", "a", "k", "e", "d", 8'h00, 8'h00, 8'h00},
    '{"p", "o", "w", "e", "r", "e", "d", 8'h00},
    '{"o", "r", "d", "e", "r", 8'h00, 8'h00, 8'h00},
    '{"c", "a", "n", "c", "e", "l", 8'h00, 8'h00},
    '{"1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{5, 7, 5, 6, 1, 3};

  // One processed beat: whether it closes a frame, and the result it carries.
  typedef struct packed {
    logic       fire;
    logic [2:0] code;
    logic [7:0] count;
  } fkcd_result_t;

endpackage

`default_nettype wire

### design/fkcd_match.sv
// Keyword matcher: compares the leading command buffer bytes with the keyword table.
// Depends on fkcd_pkg.
`default_nettype none

module fkcd_match (
  input  wire fkcd_pkg::key_buf_t buffer,
  output logic [2:0]              code
);

  logic [fkcd_pkg::KW_COUNT-1:0] hit;

  // A keyword hits when its characters and the zero after it are all present.
  always_comb begin
    for (int i = 0; i < fkcd_pkg::KW_COUNT; i++) begin
      hit[i] = 1'b1;
      for (int k = 0; k < fkcd_pkg::KEY_BYTES; k++) begin
        if (k <= fkcd_pkg::KW_LEN[i] && buffer[k] != fkcd_pkg::KW_TEXT[i][k]) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  // First hit wins.
  always_comb begin
    code = fkcd_pkg::CODE_NO_MATCH;
    for (int i = fkcd_pkg::KW_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        code = fkcd_pkg::CODE_WAKED + 3'(i);
      end
    end
  end

endmodule

`default_nettype wire

### design/fkcd_frame.sv
// Frame tracker: hunt/collect state, leading command bytes, write position and count.
// Depends on fkcd_pkg and fkcd_match.
`default_nettype none

module fkcd_frame (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         step,
  input  wire  [7:0]                  data,
  input  wire  [7:0]                  start_char,
  input  wire  [7:0]                  end_char,
  output fkcd_pkg::fkcd_result_t      result
);

  logic                        collecting;
  logic [fkcd_pkg::WPOS_W-1:0] write_pos;
  logic [7:0]                  byte_count;
  fkcd_pkg::key_buf_t          buffer;

  logic [2:0] match_code;
  logic       is_end;
  logic       store_hit;

  fkcd_match u_match (
    .buffer (buffer),
    .code   (match_code)
  );

  assign is_end    = (data == end_char);
  // Bytes stored beyond the leading window never affect a match.
  assign store_hit = fkcd_pkg::WPOS_EXT_W'(write_pos)
                     < fkcd_pkg::WPOS_EXT_W'(fkcd_pkg::KEY_BYTES);

  always_comb begin
    result.fire  = step && collecting && is_end;
    result.code  = match_code;
    result.count = byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      write_pos  <= '0;
      byte_count <= '0;
      for (int k = 0; k < fkcd_pkg::KEY_BYTES; k++) begin
        buffer[k] <= '0;
      end
    end else if (step) begin
      if (!collecting) begin
        if (data == start_char) begin
          collecting <= 1'b1;
          write_pos  <= '0;
          byte_count <= '0;
          for (int k = 0; k < fkcd_pkg::KEY_BYTES; k++) begin
            buffer[k] <= '0;
          end
        end
      end else if (is_end) begin
        collecting <= 1'b0;
        write_pos  <= '0;
      end else begin
        if (store_hit) begin
          buffer[write_pos[fkcd_pkg::KIDX_W-1:0]] <= data;
        end
        if (write_pos == fkcd_pkg::WPOS_W'(fkcd_pkg::CMD_BUF_SIZE - 1)) begin
          write_pos <= '0;
        end else begin
          write_pos <= write_pos + 1'b1;
        end
        if (byte_count != fkcd_pkg::COUNT_MAX) begin
          byte_count <= byte_count + 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/framed_keyword_command_decoder.sv
// A frame's closing beat, once accepted, waits in the input register until the frame logic
// advances; the result register loads the result at that same edge. A full result register
// whose output is stalled holds the frame logic back.
// Throughput: one beat per cycle while the result side does not stall.
// The input register takes a new beat while a result waits, as long as the frame logic
// can advance into a free or emptying result register. Reset (rst, synchronous, active
// high) returns to hunting, clears the buffer and counters, and sets the start and end
// characters to '%' and '$'.
// Depends on fkcd_pkg and fkcd_frame.
`default_nettype none

module framed_keyword_command_decoder (
  input  wire        clk,
  input  wire        rst,

  // Configuration write port.
  input  wire        write_enable,
  input  wire        reg_index,
  input  wire  [7:0] write_data,

  // Received bytes.
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] rx_byte,

  // Decoded commands.
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] command_code,
  output logic [7:0] frame_bytes
);

  logic [7:0] start_char;
  logic [7:0] end_char;

  // Input register: holds one beat until the frame logic consumes it.
  logic       held_valid;
  logic [7:0] held_byte;

  logic                   advance;
  fkcd_pkg::fkcd_result_t result;

  // The frame logic consumes the held beat whenever the result register can take
  // whatever that beat produces; a beat that closes no frame produces nothing, but we
  // keep the rule uniform so results stay in order.
  assign advance  = held_valid && (!out_valid || !out_stall);
  // A new beat may enter when the register is empty or being emptied this cycle.
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= fkcd_pkg::START_CHAR_RESET;
      end_char   <= fkcd_pkg::END_CHAR_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        fkcd_pkg::REG_START_CHAR: start_char <= write_data;
        fkcd_pkg::REG_END_CHAR:   end_char   <= write_data;
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

  fkcd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data       (held_byte),
    .start_char (start_char),
    .end_char   (end_char),
    .result     (result)
  );

  // Result register: loads when a closing beat is processed, drains when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.fire) begin
      command_code <= result.code;
      frame_bytes  <= result.count;
    end
  end

endmodule

`default_nettype wire

### tb/fkcd_command_checker.sv
// Checker for the framed keyword command decoder: predicts the decoded command of every
// frame from the accepted byte beats and compares it with each accepted result beat.
// Depends on fkcd_pkg for the buffer size, the byte type and the register indexes.
module fkcd_command_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic       reg_index,
  input  logic [7:0] write_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] command_code,
  input  logic [7:0] frame_bytes,
  output int         mismatches,
  output int         expected_left
);

  typedef enum logic [2:0] {
    CMD_WAKED, CMD_POWERED, CMD_ORDER, CMD_CANCEL, CMD_SETUP, CMD_OFF, CMD_UNKNOWN
  } command_e;

  typedef struct packed {
    command_e   code;
    logic [7:0] count;
  } decoded_t;

  localparam fkcd_pkg::byte_t OPEN_DEFAULT  = "%";
  localparam fkcd_pkg::byte_t CLOSE_DEFAULT = "$";

  // Keyword list in priority order; the index is the command code.
  string keyword_list [6] = '{"waked", "powered", "order", "cancel", "1", "off"};

  fkcd_pkg::byte_t open_copy;
  fkcd_pkg::byte_t close_copy;
  bit              collecting;
  fkcd_pkg::byte_t cmd_copy [fkcd_pkg::CMD_BUF_SIZE];
  int              wr_pos;
  int              payload_count;
  decoded_t        decoded_q [$];
  int              err_count;
  int              pending_n;

  assign mismatches    = err_count;
  assign expected_left = pending_n;

  initial begin
    err_count = 0;
    pending_n = 0;
  end

  function automatic bit keyword_hit(string kw);
    int k;
    for (k = 0; k < kw.len(); k++) begin
      if (k >= fkcd_pkg::CMD_BUF_SIZE) return 1'b0;
      if (cmd_copy[k] != kw[k]) return 1'b0;
    end
    // The byte after the keyword must be zero, unless the keyword fills the buffer.
    if (kw.len() < fkcd_pkg::CMD_BUF_SIZE) return cmd_copy[kw.len()] == 8'h00;
    return 1'b1;
  endfunction

  function automatic command_e classify_buffer();
    int i;
    for (i = 0; i < 6; i++) begin
      if (keyword_hit(keyword_list[i])) return command_e'(i);
    end
    return CMD_UNKNOWN;
  endfunction

  function automatic void take_byte(fkcd_pkg::byte_t b);
    decoded_t res;
    if (!collecting) begin
      if (b == open_copy) begin
        collecting = 1'b1;
        foreach (cmd_copy[i]) cmd_copy[i] = 8'h00;
        wr_pos        = 0;
        payload_count = 0;
      end
    end else if (b == close_copy) begin
      res.code  = classify_buffer();
      res.count = payload_count[7:0];
      decoded_q.push_back(res);
      collecting = 1'b0;
      wr_pos     = 0;
    end else begin
      cmd_copy[wr_pos] = b;
      wr_pos = (wr_pos + 1) % fkcd_pkg::CMD_BUF_SIZE;
      if (payload_count < 255) payload_count++;
    end
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      open_copy     = OPEN_DEFAULT;
      close_copy    = CLOSE_DEFAULT;
      collecting    = 1'b0;
      foreach (cmd_copy[i]) cmd_copy[i] = 8'h00;
      wr_pos        = 0;
      payload_count = 0;
      decoded_q.delete();
    end else begin
      if (write_enable) begin
        if (reg_index == fkcd_pkg::REG_START_CHAR) open_copy = write_data;
        else close_copy = write_data;
      end
      // A result never belongs to a byte taken at the same edge, so check first.
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected command beat, code %0d, bytes %0d",
                   $time, command_code, frame_bytes);
        end else begin
          want = decoded_q.pop_front();
          if (command_code !== want.code) begin
            err_count++;
            $display("%0t: command_code expected %0d, got %0d",
                     $time, want.code, command_code);
          end
          if (frame_bytes !== want.count) begin
            err_count++;
            $display("%0t: frame_bytes expected %0d, got %0d",
                     $time, want.count, frame_bytes);
          end
        end
      end
      if (in_valid && !in_stall) take_byte(rx_byte);
    end
    pending_n <= decoded_q.size();
  end

endmodule

### tb/framed_keyword_command_decoder_tb.sv
// Top of the framed keyword command decoder testbench: clock, reset, byte stimulus,
// result-side stall pattern and the final verdict. Depends on fkcd_pkg, the decoder RTL
// and fkcd_command_checker, which does all prediction and comparison.
module framed_keyword_command_decoder_tb;

  // Far above the slowest correct run of roughly 1800 beats with heavy idling.
  localparam int CYCLE_LIMIT = 300000;
  // A closing beat passes the input register before the result register loads; allow a margin.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_BEATS   = 240;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       write_enable = 1'b0;
  logic       reg_index = fkcd_pkg::REG_START_CHAR;
  logic [7:0] write_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [2:0] command_code;
  wire  [7:0] frame_bytes;
  int         mismatches;
  int         expected_left;

  // Stimulus knobs shared between the byte sender and the result-side staller.
  int              send_idle = 17;
  int              recv_idle = 70;
  logic            hold_req = 1'b0;
  int              hold_left = 0;
  int              beats_sent = 0;
  int              cycle_count = 0;
  fkcd_pkg::byte_t open_char = "%";
  fkcd_pkg::byte_t close_char = "$";

  string keyword_pool [6] = '{"waked", "powered", "order", "cancel", "1", "off"};

  // Frame delimiters for each phase: the reset pair, both extremes each way round,
  // a start character equal to the end character, the reset pair again, and a random
  // pair that is filled in at run time.
  fkcd_pkg::byte_t phase_open  [6] = '{"%", 8'h00, 8'hFF, "Z", "%", 8'h00};
  fkcd_pkg::byte_t phase_close [6] = '{"$", 8'hFF, 8'h00, "Z", "$", 8'h00};

  framed_keyword_command_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_code (command_code),
    .frame_bytes  (frame_bytes)
  );

  fkcd_command_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .write_enable  (write_enable),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command_code  (command_code),
    .frame_bytes   (frame_bytes),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result-side stall. A pulse on hold_req starts a long hold-off that this process
  // counts down by itself; otherwise the stall is random at the current idle rate.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Offers one byte beat and returns at the edge where it is taken. The valid line is
  // left high on return, so back-to-back beats need no second assignment in a step.
  task automatic send_beat(input fkcd_pkg::byte_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i]);
  endtask

  task automatic send_frame(input fkcd_pkg::byte_t body [$]);
    send_beat(open_char);
    foreach (body[i]) send_beat(body[i]);
    send_beat(close_char);
  endtask

  // A random payload byte that does not close the frame.
  function automatic fkcd_pkg::byte_t payload_byte(input bit allow_zero);
    fkcd_pkg::byte_t b;
    b = fkcd_pkg::byte_t'($urandom_range(255));
    while (b == close_char || (!allow_zero && b == 8'h00))
      b = fkcd_pkg::byte_t'($urandom_range(255));
    return b;
  endfunction

  // Stops offering beats and waits until every decoded command has come back, plus
  // the pipeline latency so that a trailing byte that closes nothing is also consumed.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both delimiter registers are written one after the other with the enable held.
  task automatic write_delimiters(input fkcd_pkg::byte_t o, input fkcd_pkg::byte_t c);
    write_enable <= 1'b1;
    reg_index    <= fkcd_pkg::REG_START_CHAR;
    write_data   <= o;
    @(posedge clk);
    reg_index    <= fkcd_pkg::REG_END_CHAR;
    write_data   <= c;
    @(posedge clk);
    write_enable <= 1'b0;
    open_char  = o;
    close_char = c;
  endtask

  // One random frame. Close to half are well formed keyword frames so that every command code
  // comes up often; the rest are near misses, zero bytes that cut the text short,
  // random bodies, frames long enough to wrap the buffer, frames whose wrapped tail
  // rewrites a keyword over the head, a start byte inside a frame, and line noise.
  task automatic random_frame();
    fkcd_pkg::byte_t body [$];
    string           kw;
    int              kind;
    int              n;
    int              i;
    kw   = keyword_pool[$urandom_range(5)];
    kind = $urandom_range(99);
    if (kind < 6) begin
      n = $urandom_range(1, 4);
      repeat (n) send_beat(fkcd_pkg::byte_t'($urandom_range(255)));
    end else begin
      if (kind < 50) begin
        for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
      end else if (kind < 62) begin
        // Near miss: one character short or one too many.
        for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
        if ($urandom_range(1)) void'(body.pop_back());
        else body.push_back(payload_byte(1'b1));
      end else if (kind < 72) begin
        // A zero after the keyword ends the compared text, whatever follows.
        for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
        body.push_back(8'h00);
        n = $urandom_range(0, 3);
        repeat (n) body.push_back(payload_byte(1'b1));
      end else if (kind < 84) begin
        n = $urandom_range(0, 8);
        repeat (n) body.push_back(payload_byte(1'b1));
      end else if (kind < 90) begin
        n = $urandom_range(fkcd_pkg::CMD_BUF_SIZE + 1, 70);
        repeat (n) body.push_back(payload_byte(1'b1));
      end else if (kind < 95) begin
        // Fill the buffer with a zero just past the keyword's length, then let the
        // wrapped write position lay the keyword over the first bytes.
        for (i = 0; i < fkcd_pkg::CMD_BUF_SIZE; i++)
          body.push_back((i == kw.len()) ? 8'h00 : payload_byte(1'b0));
        for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
      end else begin
        // A start byte while collecting is only payload.
        body.push_back(open_char);
        for (i = 0; i < kw.len(); i++) body.push_back(kw[i]);
      end
      send_frame(body);
    end
  endtask

  initial begin
    int              ph;
    int              target;
    fkcd_pkg::byte_t long_body [$];

    // Synchronous reset held from time zero, released on an edge like any other input.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under the reset delimiters: bytes of both extremes while
    // hunting, the shortest and the longest keyword, a start byte and a zero inside a
    // frame, an empty frame, and a keyword followed by an all-ones byte.
    send_beat(8'h00);
    send_beat(8'hFF);
    send_text("%1$");
    send_text("%powered$");
    send_text("%%");
    send_beat(8'h00);
    send_text("$");
    send_text("%$");
    send_text("%off");
    send_beat(8'hFF);
    send_text("$");

    phase_open[5]  = fkcd_pkg::byte_t'($urandom_range(255));
    phase_close[5] = fkcd_pkg::byte_t'($urandom_range(255));

    for (ph = 0; ph < 6; ph++) begin
      // The sender pauses here until every expected command has come back.
      drain_decoder();
      if (ph != 0) write_delimiters(phase_open[ph], phase_close[ph]);

      // Idle pattern: sender light and receiver heavy, then the reverse, then none.
      if (ph < 2) begin
        send_idle = 17;
        recv_idle = 70;
      end else if (ph < 4) begin
        send_idle = 70;
        recv_idle = 17;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      // Long result-side hold-off while bytes keep coming, so the decoder backs up
      // and pushes back on its input.
      if (ph == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end

      // One frame long enough to saturate the byte count.
      if (ph == 5) begin
        repeat (270) long_body.push_back(payload_byte(1'b1));
        send_frame(long_body);
      end

      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) random_frame();
    end

    drain_decoder();

    if (mismatches == 0 && expected_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
